FILE: sv/checksummed_frame_deframer_top_macros.svh
// assertion helpers shared by the deframer
`ifndef CHECKSUMMED_FRAME_DEFRAMER_TOP_MACROS_SVH
`define CHECKSUMMED_FRAME_DEFRAMER_TOP_MACROS_SVH

// consequence must hold in the same cycle as the antecedent
`define CFD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence must hold in the cycle after the antecedent
`define CFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/cfd_pkg.sv
package cfd_pkg;

    // frame constants
    localparam logic [15:0] HDR_MAGIC   = 16'hA00B;
    localparam logic [16:0] MIN_FRAME_M1 = 17'd7;   // minimum frame length minus one
    localparam logic [15:0] CMD_BYTES   = 16'd2;
    localparam logic [16:0] POS_MAX     = 17'h1FFFF;

    // byte positions inside a frame
    localparam logic [16:0] POS_HDR_HI  = 17'd0;
    localparam logic [16:0] POS_HDR_LO  = 17'd1;
    localparam logic [16:0] POS_VERSION = 17'd2;
    localparam logic [16:0] POS_SEQ     = 17'd3;
    localparam logic [16:0] POS_OPCODE  = 17'd4;
    localparam logic [16:0] POS_LEN_HI  = 17'd5;
    localparam logic [16:0] POS_LEN_LO  = 17'd6;
    localparam logic [16:0] POS_CMD_HI  = 17'd7;
    localparam logic [16:0] POS_CMD_LO  = 17'd8;
    localparam logic [16:0] POS_DATA    = 17'd9;

    // result queue depth
    localparam int CFD_FIFO_DEPTH = 4;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_VERDICT = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        ST_DELIVERED = 3'd0,
        ST_OK_EMPTY  = 3'd1,
        ST_SHORT     = 3'd2,
        ST_HEADER    = 3'd3,
        ST_REPEAT    = 3'd4,
        ST_LENGTH    = 3'd5,
        ST_CHECKSUM  = 3'd6
    } t_status;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        t_status     status;
        logic [7:0]  opcode;
        logic [7:0]  version;
        logic [15:0] command;
        logic [15:0] payload_count;
        logic        end_of_run;
    } t_result;

    // write strobes for the two result slots of one transfer
    typedef struct packed {
        logic en0;
        logic en1;
    } t_push;

endpackage

FILE: sv/cfd_parser.sv
module cfd_parser
    import cfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    input  logic       i_last_byte,
    output t_push      o_push,
    output t_result    o_res0,
    output t_result    o_res1
);

    logic [7:0]  r_last_seq,   n_last_seq;
    logic [16:0] r_pos,        n_pos;
    logic [7:0]  r_sum,        n_sum;
    logic [15:0] r_header,     n_header;
    logic [7:0]  r_version,    n_version;
    logic [7:0]  r_seq,        n_seq;
    logic [7:0]  r_opcode,     n_opcode;
    logic [15:0] r_length,     n_length;
    logic [15:0] r_command,    n_command;
    logic [7:0]  r_held_byte,  n_held_byte;
    logic        r_held_valid, n_held_valid;

    t_result w_held;
    t_result w_verdict;

    // frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_seq   <= '0;
            r_pos        <= '0;
            r_sum        <= '0;
            r_header     <= '0;
            r_version    <= '0;
            r_seq        <= '0;
            r_opcode     <= '0;
            r_length     <= '0;
            r_command    <= '0;
            r_held_byte  <= '0;
            r_held_valid <= 1'b0;
        end else begin
            r_last_seq   <= n_last_seq;
            r_pos        <= n_pos;
            r_sum        <= n_sum;
            r_header     <= n_header;
            r_version    <= n_version;
            r_seq        <= n_seq;
            r_opcode     <= n_opcode;
            r_length     <= n_length;
            r_command    <= n_command;
            r_held_byte  <= n_held_byte;
            r_held_valid <= n_held_valid;
        end
    end

    // held data byte as a tentative payload result
    always_comb begin
        w_held              = '0;
        w_held.kind         = KIND_PAYLOAD;
        w_held.payload_byte = r_held_byte;
        w_held.status       = ST_DELIVERED;
        w_held.end_of_run   = !i_last_byte;
    end

    // verdict checks in priority order, sequence update once the repeat check passes
    always_comb begin
        w_verdict            = '0;
        w_verdict.kind       = KIND_VERDICT;
        w_verdict.opcode     = r_opcode;
        w_verdict.version    = r_version;
        w_verdict.end_of_run = 1'b1;
        n_last_seq           = r_last_seq;
        if (r_pos < MIN_FRAME_M1) begin
            w_verdict.status  = ST_SHORT;
            w_verdict.opcode  = '0;
            w_verdict.version = '0;
        end else if (r_header != HDR_MAGIC) begin
            w_verdict.status = ST_HEADER;
        end else if (r_seq != '0 && r_seq == r_last_seq) begin
            w_verdict.status = ST_REPEAT;
        end else begin
            n_last_seq = r_seq;
            if (({1'b0, r_length} + MIN_FRAME_M1) != r_pos) begin
                w_verdict.status = ST_LENGTH;
            end else if (r_sum != i_rx_byte) begin
                w_verdict.status = ST_CHECKSUM;
            end else if (r_length > CMD_BYTES) begin
                w_verdict.status        = ST_DELIVERED;
                w_verdict.command       = r_command;
                w_verdict.payload_count = r_length - CMD_BYTES;
            end else begin
                w_verdict.status = ST_OK_EMPTY;
            end
        end
        if (!(i_accept && i_last_byte)) begin
            n_last_seq = r_last_seq;
        end
    end

    // field capture, running sum, position count and result slots
    always_comb begin
        n_pos        = r_pos;
        n_sum        = r_sum;
        n_header     = r_header;
        n_version    = r_version;
        n_seq        = r_seq;
        n_opcode     = r_opcode;
        n_length     = r_length;
        n_command    = r_command;
        n_held_byte  = r_held_byte;
        n_held_valid = r_held_valid;
        o_push       = '0;
        o_res0       = w_held;
        o_res1       = w_verdict;
        if (i_accept && !i_last_byte) begin
            o_push.en0 = (r_pos >= POS_DATA) && r_held_valid;
            unique case (r_pos)
                POS_HDR_HI:  n_header[15:8]  = i_rx_byte;
                POS_HDR_LO:  n_header[7:0]   = i_rx_byte;
                POS_VERSION: n_version       = i_rx_byte;
                POS_SEQ:     n_seq           = i_rx_byte;
                POS_OPCODE:  n_opcode        = i_rx_byte;
                POS_LEN_HI:  n_length[15:8]  = i_rx_byte;
                POS_LEN_LO:  n_length[7:0]   = i_rx_byte;
                POS_CMD_HI:  n_command[15:8] = i_rx_byte;
                POS_CMD_LO:  n_command[7:0]  = i_rx_byte;
                default: begin
                    n_held_byte  = i_rx_byte;
                    n_held_valid = 1'b1;
                end
            endcase
            n_sum = r_sum + i_rx_byte;
            if (r_pos < POS_MAX) begin
                n_pos = r_pos + 17'd1;
            end
        end else if (i_accept) begin
            // final byte: flush held byte first, then the verdict
            if (r_held_valid) begin
                o_push.en0 = 1'b1;
                o_push.en1 = 1'b1;
            end else begin
                o_push.en0 = 1'b1;
                o_res0     = w_verdict;
            end
            n_pos        = '0;
            n_sum        = '0;
            n_header     = '0;
            n_version    = '0;
            n_seq        = '0;
            n_opcode     = '0;
            n_length     = '0;
            n_command    = '0;
            n_held_byte  = '0;
            n_held_valid = 1'b0;
        end
    end

endmodule

FILE: sv/cfd_fifo.sv
module cfd_fifo
    import cfd_pkg::*;
#(
    parameter int P_DEPTH = CFD_FIFO_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_push                        i_push,
    input  t_result                      i_res0,
    input  t_result                      i_res1,
    input  logic                         i_pop,
    output t_result                      o_head,
    output logic                         o_valid,
    output logic                         o_room2,
    output logic [$clog2(P_DEPTH+1)-1:0] o_count
);

    localparam int L_PTR_W = $clog2(P_DEPTH);
    localparam int L_CNT_W = $clog2(P_DEPTH + 1);

    t_result              r_mem [P_DEPTH];
    logic [L_PTR_W-1:0]   r_wr, n_wr;
    logic [L_PTR_W-1:0]   r_rd, n_rd;
    logic [L_CNT_W-1:0]   r_count, n_count;
    logic [L_PTR_W-1:0]   w_wr1;
    logic                 w_pop;

    function automatic logic [L_PTR_W-1:0] ptr_inc(input logic [L_PTR_W-1:0] p);
        logic [L_PTR_W-1:0] q;
        if (p == L_PTR_W'(P_DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + L_PTR_W'(1);
        end
        return q;
    endfunction

    assign w_wr1 = ptr_inc(r_wr);
    assign w_pop = i_pop && (r_count != '0);

    // storage writes, second slot follows the first
    always_ff @(posedge i_clk) begin
        if (i_push.en0) begin
            r_mem[r_wr] <= i_res0;
        end
        if (i_push.en1) begin
            r_mem[w_wr1] <= i_res1;
        end
    end

    // pointer and fill count
    always_comb begin
        n_wr = r_wr;
        if (i_push.en1) begin
            n_wr = ptr_inc(w_wr1);
        end else if (i_push.en0) begin
            n_wr = w_wr1;
        end
        n_rd    = w_pop ? ptr_inc(r_rd) : r_rd;
        n_count = r_count + L_CNT_W'(i_push.en0) + L_CNT_W'(i_push.en1)
                  - L_CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_valid = (r_count != '0);
    assign o_room2 = (r_count <= L_CNT_W'(P_DEPTH - 2));
    assign o_count = r_count;

endmodule

FILE: sv/checksummed_frame_deframer_top.sv
// checksummed frame deframer
// input channel: one received frame byte per transfer on i_rx_byte, with
// i_last_byte high on the final (checksum) byte; valid/ready handshake.
// output channel: result items on valid/ready. a payload byte from position
// nine on comes out one byte late as a tentative kind 0 result; the final
// byte yields the verdict (kind 1), preceded by the last held payload byte, if any.
// throughput: one input byte per cycle while input ready is high. each
// accepted byte is parsed in the cycle it is taken and its results are
// written into a small result queue in that cycle. the queue takes two
// writes and gives one read per cycle; input ready drops only when it has
// room for fewer than two results, which happens when the receiver stalls
// and results build up in the queue.
// a receiver stall therefore backs up into the input after the queue fills.
// reset (synchronous, active low) clears the frame state, the stored
// sequence number and the queue; no result is pending after reset.
module checksummed_frame_deframer_top
    import cfd_pkg::*;
#(
    parameter int P_FIFO_DEPTH = CFD_FIFO_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_result_kind,
    output logic [7:0]  o_payload_byte,
    output logic [2:0]  o_status,
    output logic [7:0]  o_opcode,
    output logic [7:0]  o_version,
    output logic [15:0] o_command,
    output logic [15:0] o_payload_count,
    output logic        o_end_of_run
);

`include "checksummed_frame_deframer_top_macros.svh"

    localparam int L_CNT_W = $clog2(P_FIFO_DEPTH + 1);

    logic               w_accept;
    t_push              w_push;
    t_result            w_res0;
    t_result            w_res1;
    t_result            w_head;
    logic [L_CNT_W-1:0] w_count;

    assign w_accept = i_valid && o_ready;

    // byte parser and verdict logic
    cfd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_rx_byte   (i_rx_byte),
        .i_last_byte (i_last_byte),
        .o_push      (w_push),
        .o_res0      (w_res0),
        .o_res1      (w_res1)
    );

    // result queue
    cfd_fifo #(
        .P_DEPTH (P_FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_res0  (w_res0),
        .i_res1  (w_res1),
        .i_pop   (i_ready),
        .o_head  (w_head),
        .o_valid (o_valid),
        .o_room2 (o_ready),
        .o_count (w_count)
    );

    // output fields
    assign o_result_kind   = w_head.kind;
    assign o_payload_byte  = w_head.payload_byte;
    assign o_status        = w_head.status;
    assign o_opcode        = w_head.opcode;
    assign o_version       = w_head.version;
    assign o_command       = w_head.command;
    assign o_payload_count = w_head.payload_count;
    assign o_end_of_run    = w_head.end_of_run;

    // checks
    `CFD_ASSERT_NOW(a_count_bound, 1'b1, w_count <= L_CNT_W'(P_FIFO_DEPTH), "queue overfilled")
    `CFD_ASSERT_NOW(a_push_order, w_push.en1, w_push.en0, "second slot written without first")
    `CFD_ASSERT_NEXT(a_verdict_queued, w_accept && i_last_byte, o_valid, "verdict not queued")
    `CFD_ASSERT_NOW(a_payload_status, o_valid && o_result_kind == KIND_PAYLOAD,
                    o_status == ST_DELIVERED, "payload result with nonzero status")

endmodule
